[design/wpf_pkg.sv]
// Shared types, constants and small tables of the waypoint path follower.
// Depends on nothing; used by the interfaces, the bearing unit and the top level.
package wpf_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         waypoint_index;
    logic [7:0]         waypoint_x;
    logic [7:0]         waypoint_y;
    logic [4:0]         path_count;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [14:0]        heading;
    logic               turn_enable;
  } in_t;

  typedef struct packed {
    logic [14:0]        heading_out;
    logic               arrived;
    logic               active;
    logic               cell_update;
    logic [7:0]         cell_x;
    logic [7:0]         cell_y;
    logic signed [19:0] set_x;
    logic signed [19:0] set_y;
  } out_t;

  // Request to the bearing unit: offset from mover to set point, 1/16 units.
  typedef struct packed {
    logic               start;
    logic signed [20:0] nx;
    logic signed [20:0] ny;
  } brg_req_t;

  localparam logic [14:0] FULL_TURN = 15'd23040;
  localparam logic [14:0] HALF_TURN = 15'd11520;
  localparam logic [14:0] QTR_TURN  = 15'd5760;
  localparam logic [14:0] TQTR_TURN = 15'd17280;
  localparam logic [14:0] SNAP_GAP  = 15'd2880;
  localparam logic [42:0] NEAR_SQ   = 43'd102400;

  // Cubic weights in 1/128; the last row lands exactly on the next waypoint.
  function automatic logic signed [8:0] weight(input logic [1:0] sub, input logic [1:0] tap);
    logic signed [8:0] w;
    w = 9'sd0;
    case ({sub, tap})
      4'h0: w = -9'sd9;
      4'h1: w = 9'sd111;
      4'h2: w = 9'sd29;
      4'h3: w = -9'sd3;
      4'h4: w = -9'sd8;
      4'h5: w = 9'sd72;
      4'h6: w = 9'sd72;
      4'h7: w = -9'sd8;
      4'h8: w = -9'sd3;
      4'h9: w = 9'sd29;
      4'hA: w = 9'sd111;
      4'hB: w = -9'sd9;
      4'hE: w = 9'sd128;
      default: w = 9'sd0;
    endcase
    return w;
  endfunction

  // Arc tangent of 2^-i in 1/16384 degree.
  function automatic logic [19:0] atan_step(input logic [3:0] i);
    logic [19:0] a;
    a = 20'd0;
    case (i)
      4'd0:  a = 20'd737280;
      4'd1:  a = 20'd435242;
      4'd2:  a = 20'd229970;
      4'd3:  a = 20'd116736;
      4'd4:  a = 20'd58595;
      4'd5:  a = 20'd29326;
      4'd6:  a = 20'd14667;
      4'd7:  a = 20'd7334;
      4'd8:  a = 20'd3667;
      4'd9:  a = 20'd1833;
      4'd10: a = 20'd917;
      4'd11: a = 20'd458;
      4'd12: a = 20'd229;
      4'd13: a = 20'd115;
      4'd14: a = 20'd57;
      4'd15: a = 20'd29;
      default: a = 20'd0;
    endcase
    return a;
  endfunction

endpackage

[design/wpf_if.sv]
// Valid/ready channels of the waypoint path follower, one per direction.
// Depends on wpf_pkg for the word types.
interface wpf_in_if;
  logic         valid;
  logic         ready;
  wpf_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wpf_out_if;
  logic          valid;
  logic          ready;
  wpf_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/wpf_store.sv]
// Waypoint store: column and row per slot, one write and one registered read.
// Depends on nothing.
module wpf_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wcol_i,
  input  logic [7:0]    wrow_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rcol_o,
  output logic [7:0]    rrow_o
);

  logic [7:0] col_mem [DEPTH];
  logic [7:0] row_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      col_mem[waddr_i] <= wcol_i;
      row_mem[waddr_i] <= wrow_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rcol_o <= col_mem[raddr_i];
      rrow_o <= row_mem[raddr_i];
    end
  end

endmodule

[design/wpf_cordic.sv]
// Bearing unit: 16-step vectoring CORDIC, one micro-rotation per cycle.
// Depends on wpf_pkg for the request type, the arc tangent table and turn constants.
module wpf_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wpf_pkg::brg_req_t req_i,
  output logic              done_o,
  output logic [14:0]       bearing_o
);

  typedef enum logic [1:0] {C_IDLE, C_ITER, C_WRAP} cst_e;

  localparam logic signed [24:0] Z_HALF = 25'sd2949120;
  localparam logic signed [24:0] Z_QTR  = 25'sd1474560;
  localparam logic signed [24:0] Z_FULL = 25'sd5898240;

  cst_e              st_q;
  logic [3:0]        i_q;
  logic signed [43:0] x_q, y_q;
  logic signed [24:0] z_q;

  logic signed [43:0] x0, y0, xs, ys;
  logic signed [24:0] at, fine;
  logic [22:0]        fine_r;
  logic [14:0]        b_raw;
  logic               y_pos;

  always_comb begin
    x0 = $signed({{3{req_i.nx[20]}}, req_i.nx, 20'b0});
    y0 = $signed({{3{req_i.ny[20]}}, req_i.ny, 20'b0});
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = $signed({5'b0, wpf_pkg::atan_step(i_q)});
    y_pos = !y_q[43] && (y_q != '0);
    fine = z_q + Z_QTR;
    if (fine < 0) begin
      fine = fine + Z_FULL;
    end else if (fine >= Z_FULL) begin
      fine = fine - Z_FULL;
    end
    fine_r = 23'(fine + 25'sd128);
    b_raw  = 15'(fine_r >> 8);
    if (b_raw >= wpf_pkg::FULL_TURN) begin
      b_raw = b_raw - wpf_pkg::FULL_TURN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= C_IDLE;
      done_o    <= 1'b0;
      i_q       <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      bearing_o <= '0;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        C_IDLE: begin
          if (req_i.start) begin
            if (req_i.nx == '0) begin
              bearing_o <= req_i.ny[20] ? 15'd0 : wpf_pkg::HALF_TURN;
              done_o    <= 1'b1;
            end else if (req_i.ny == '0) begin
              bearing_o <= req_i.nx[20] ? wpf_pkg::TQTR_TURN : wpf_pkg::QTR_TURN;
              done_o    <= 1'b1;
            end else begin
              // fold the left half plane over and preload half a turn
              x_q  <= req_i.nx[20] ? -x0 : x0;
              y_q  <= req_i.nx[20] ? -y0 : y0;
              z_q  <= req_i.nx[20] ? Z_HALF : 25'sd0;
              i_q  <= '0;
              st_q <= C_ITER;
            end
          end
        end
        C_ITER: begin
          if (y_pos) begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + at;
          end else begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - at;
          end
          i_q <= i_q + 4'd1;
          if (i_q == 4'd15) begin
            st_q <= C_WRAP;
          end
        end
        C_WRAP: begin
          bearing_o <= b_raw;
          done_o    <= 1'b1;
          st_q      <= C_IDLE;
        end
        default: st_q <= C_IDLE;
      endcase
    end
  end

endmodule

[design/spline_waypoint_path_follower.sv]
// Waypoint path follower top level: sequencer, set point arithmetic, steering.
// Depends on wpf_pkg, wpf_in_if/wpf_out_if, wpf_store and wpf_cordic.
//
//   channel | dir | word                          | accepted when
//   --------+-----+-------------------------------+-------------------------
//   in_i    | in  | op, waypoint, count, mover    | in_i.valid & in_i.ready
//   out_o   | out | heading, flags, cell, set pt  | out_o.valid & out_o.ready
//
// Write, start and idle words go from the idle state straight to the finish state.
// A step with an active path reads five store entries through the single read port
// (a read state and an accumulate state each), then scales, rounds, measures
// distance and decides, and loads the result in the finish state. When it steers,
// it waits for the CORDIC bearing unit and then works out the gap and the turn.
// Reset (rst_ni low, asynchronous) empties the path; store contents stay
// undefined until written. A result word waits in the output register while
// the next input word is taken; a finished item holds until that register frees.
module spline_waypoint_path_follower #(
  parameter int MAX_WAYPOINTS = 16,
  parameter int CELL_SIZE     = 100
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  wpf_in_if.sink        in_i,
  wpf_out_if.source     out_o
);

  localparam int AW = (MAX_WAYPOINTS > 2) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam logic [8:0]  MaxWp     = 9'(MAX_WAYPOINTS);
  localparam logic [11:0] CellScale = 12'(CELL_SIZE * 8);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MAC, S_SCALE, S_ROUND, S_DIST, S_NEAR,
    S_BRG, S_GAP, S_TURN, S_FIN
  } state_e;

  state_e             state_q;
  wpf_pkg::op_e       op_q;
  logic signed [19:0] px_q, py_q, setx_q, sety_q;
  logic [14:0]        h_q, b_q, d_q, hout_q;
  logic               turn_q, arr_q, cupd_q, act_q;
  logic [4:0]         count_q, seg_q;
  logic [1:0]         sub_q;
  logic [2:0]         r_q;
  logic signed [17:0] accx_q, accy_q;
  logic signed [29:0] prodx_q, prody_q;
  logic signed [20:0] nx_q, ny_q;
  logic [41:0]        dx2_q, dy2_q;
  logic [7:0]         cellx_q, celly_q, lastx_q, lasty_q;
  wpf_pkg::out_t      out_q;
  logic               out_valid_q;
  wpf_pkg::brg_req_t  brg_req_q;

  logic               accept, wr_en, brg_done;
  logic [14:0]        brg_b, hred, turn_h;
  logic [8:0]         widx9, rk9, cnt9;
  logic [4:0]         last, cnt_sat, seg_inc;
  logic [5:0]         tap_sum, k;
  logic [7:0]         rcol, rrow;
  logic signed [8:0]  w;
  logic signed [9:0]  oddx, oddy;
  logic signed [18:0] mx, my;
  logic signed [20:0] dx, dy;
  logic signed [41:0] sqx, sqy;
  logic signed [16:0] gap;
  logic [42:0]        dist2;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Store write straight from the accepted word; slots past the depth drop.
  assign widx9 = {5'b0, in_i.data.waypoint_index};
  assign wr_en = accept && (in_i.data.operation == wpf_pkg::OP_WRITE) && (widx9 < MaxWp);

  // Clamp the start count to the store depth.
  assign cnt9    = {4'b0, in_i.data.path_count};
  assign cnt_sat = (cnt9 > MaxWp) ? 5'(MaxWp) : in_i.data.path_count;

  assign hred = (in_i.data.heading >= wpf_pkg::FULL_TURN) ?
                in_i.data.heading - wpf_pkg::FULL_TURN : in_i.data.heading;

  // Tap address: taps 0..3 walk seg-1..seg+2 clamped to the path, tap 4 is the
  // final waypoint.
  assign last    = count_q - 5'd1;
  assign tap_sum = {1'b0, seg_q} + {3'b0, r_q};
  always_comb begin
    k = (tap_sum == 6'd0) ? 6'd0 : tap_sum - 6'd1;
    if (k > {1'b0, last} || r_q == 3'd4) begin
      k = {1'b0, last};
    end
  end
  assign rk9 = {3'b0, k};

  wpf_store #(.DEPTH(MAX_WAYPOINTS), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (widx9[AW-1:0]),
    .wcol_i  (in_i.data.waypoint_x),
    .wrow_i  (in_i.data.waypoint_y),
    .re_i    (state_q == S_RD),
    .raddr_i (rk9[AW-1:0]),
    .rcol_o  (rcol),
    .rrow_o  (rrow)
  );

  wpf_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (brg_req_q),
    .done_o    (brg_done),
    .bearing_o (brg_b)
  );

  // Multiply-accumulate on cell index space: centre = (2c+1) * CELL_SIZE * 8.
  assign w    = wpf_pkg::weight(sub_q, r_q[1:0]);
  assign oddx = $signed({1'b0, rcol, 1'b1});
  assign oddy = $signed({1'b0, rrow, 1'b1});
  assign mx   = w * oddx;
  assign my   = w * oddy;

  assign dx  = {px_q[19], px_q} - {setx_q[19], setx_q};
  assign dy  = {py_q[19], py_q} - {sety_q[19], sety_q};
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign dist2 = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign seg_inc = seg_q + 5'd1;

  function automatic logic signed [19:0] sat20(input logic signed [29:0] p);
    logic signed [29:0] v;
    v = (p + 30'sd64) >>> 7;
    if (v > 30'sd524287) begin
      return 20'sd524287;
    end else if (v < -30'sd524288) begin
      return -20'sd524288;
    end
    return v[19:0];
  endfunction

  // Turn by half the gap in 1/128 degree, round half up back to 1/64.
  function automatic logic [14:0] half_turn(input logic [14:0] h, input logic [14:0] b,
                                            input logic [14:0] d);
    logic signed [18:0] hh, aa2, dd, aa, r;
    logic [17:0]        rr;
    logic [14:0]        o;
    hh  = $signed({3'b0, h, 1'b0});
    aa2 = $signed({3'b0, b, 1'b0});
    dd  = $signed({4'b0, d});
    if (hh < 19'sd23040) begin
      aa = hh - dd;
      if (aa2 >= hh + dd && aa2 < hh + 19'sd23040) r = hh + dd;
      else if (aa >= 0 && (aa2 >= hh + 19'sd23040 || aa2 < aa)) r = aa;
      else if (aa < 0 && aa2 >= hh + 19'sd23040 && aa2 < aa + 19'sd46080)
        r = aa + 19'sd46080;
      else r = aa2;
    end else begin
      aa = hh + dd;
      if (aa2 < hh - dd && aa2 >= hh - 19'sd23040) r = hh - dd;
      else if (aa < 19'sd46080 && (aa2 < hh - 19'sd23040 || aa2 >= aa)) r = aa;
      else if (aa >= 19'sd46080 && aa2 < hh - 19'sd23040 && aa2 >= aa - 19'sd46080)
        r = aa - 19'sd46080;
      else r = aa2;
    end
    rr = 18'(r + 19'sd1);
    o  = 15'(rr >> 1);
    if (o >= wpf_pkg::FULL_TURN) begin
      o = o - wpf_pkg::FULL_TURN;
    end
    return o;
  endfunction

  // Angular gap between heading and bearing, shortest way round.
  always_comb begin
    gap = $signed({2'b0, b_q}) - $signed({2'b0, h_q});
    if (h_q < wpf_pkg::HALF_TURN) begin
      if ({1'b0, b_q} >= {1'b0, h_q} + {1'b0, wpf_pkg::HALF_TURN}) begin
        gap = $signed({2'b0, wpf_pkg::FULL_TURN}) - $signed({2'b0, b_q})
              + $signed({2'b0, h_q});
      end
    end else if ({1'b0, b_q} + {1'b0, wpf_pkg::HALF_TURN} < {1'b0, h_q}) begin
      gap = $signed({2'b0, wpf_pkg::FULL_TURN}) - $signed({2'b0, h_q})
            + $signed({2'b0, b_q});
    end
    if (gap < 0) begin
      gap = -gap;
    end
  end

  assign turn_h = (d_q >= wpf_pkg::SNAP_GAP) ? b_q : half_turn(h_q, b_q, d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= wpf_pkg::OP_NONE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      count_q     <= '0;
      seg_q       <= '0;
      sub_q       <= '0;
      r_q         <= '0;
      brg_req_q   <= '0;
      px_q <= '0; py_q <= '0; setx_q <= '0; sety_q <= '0;
      h_q <= '0; b_q <= '0; d_q <= '0; hout_q <= '0;
      turn_q <= 1'b0; arr_q <= 1'b0; cupd_q <= 1'b0; act_q <= 1'b0;
      accx_q <= '0; accy_q <= '0; prodx_q <= '0; prody_q <= '0;
      nx_q <= '0; ny_q <= '0; dx2_q <= '0; dy2_q <= '0;
      cellx_q <= '0; celly_q <= '0; lastx_q <= '0; lasty_q <= '0;
    end else begin
      // drop the word once taken; a finishing item reloads it below
      if (out_valid_q && out_o.ready && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q   <= wpf_pkg::op_e'(in_i.data.operation);
            px_q   <= in_i.data.pos_x;
            py_q   <= in_i.data.pos_y;
            h_q    <= hred;
            hout_q <= hred;
            turn_q <= in_i.data.turn_enable;
            arr_q  <= 1'b0;
            cupd_q <= 1'b0;
            cellx_q <= '0;
            celly_q <= '0;
            setx_q <= '0;
            sety_q <= '0;
            accx_q <= '0;
            accy_q <= '0;
            r_q    <= '0;
            act_q  <= seg_q < count_q;
            state_q <= S_FIN;
            if (in_i.data.operation == wpf_pkg::OP_START) begin
              count_q <= cnt_sat;
              seg_q   <= '0;
              sub_q   <= '0;
              act_q   <= cnt_sat != 5'd0;
            end else if (in_i.data.operation == wpf_pkg::OP_STEP && seg_q < count_q) begin
              state_q <= S_RD;
            end
          end
        end
        S_RD: state_q <= S_MAC;
        S_MAC: begin
          if (r_q == 3'd4) begin
            lastx_q <= rcol;
            lasty_q <= rrow;
            state_q <= S_SCALE;
          end else begin
            accx_q <= accx_q + 18'(mx);
            accy_q <= accy_q + 18'(my);
            // new target cell at the start of a segment
            if (r_q == 3'd2 && sub_q == 2'd0) begin
              cupd_q  <= 1'b1;
              cellx_q <= rcol;
              celly_q <= rrow;
            end
            r_q     <= r_q + 3'd1;
            state_q <= S_RD;
          end
        end
        S_SCALE: begin
          prodx_q <= accx_q * $signed({1'b0, CellScale});
          prody_q <= accy_q * $signed({1'b0, CellScale});
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          setx_q  <= sat20(prodx_q);
          sety_q  <= sat20(prody_q);
          state_q <= S_DIST;
        end
        S_DIST: begin
          dx2_q   <= 42'(sqx);
          dy2_q   <= 42'(sqy);
          nx_q    <= -dx;
          ny_q    <= -dy;
          state_q <= S_NEAR;
        end
        S_NEAR: begin
          logic arr;
          arr = 1'b0;
          if (dist2 <= wpf_pkg::NEAR_SQ) begin
            if (sub_q == 2'd3) begin
              // advance to the next segment; stop on the final one
              sub_q <= '0;
              if (seg_inc >= last) begin
                seg_q   <= last;
                cupd_q  <= 1'b1;
                cellx_q <= lastx_q;
                celly_q <= lasty_q;
                arr     = 1'b1;
              end else begin
                seg_q <= seg_inc;
              end
            end else begin
              sub_q <= sub_q + 2'd1;
            end
          end
          arr_q <= arr;
          if (!arr && turn_q) begin
            brg_req_q.start <= 1'b1;
            brg_req_q.nx    <= nx_q;
            brg_req_q.ny    <= ny_q;
            state_q         <= S_BRG;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_BRG: begin
          // the start pulse lasts one cycle
          brg_req_q.start <= 1'b0;
          if (brg_done) begin
            b_q     <= brg_b;
            state_q <= S_GAP;
          end
        end
        S_GAP: begin
          d_q     <= 15'(gap);
          state_q <= S_TURN;
        end
        S_TURN: begin
          hout_q  <= turn_h;
          state_q <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register frees
          if (!out_valid_q || out_o.ready) begin
            out_valid_q       <= 1'b1;
            out_q.heading_out <= hout_q;
            out_q.arrived     <= arr_q;
            out_q.active      <= (op_q == wpf_pkg::OP_STEP) ? act_q : (seg_q < count_q);
            out_q.cell_update <= cupd_q;
            out_q.cell_x      <= cellx_q;
            out_q.cell_y      <= celly_q;
            out_q.set_x       <= setx_q;
            out_q.set_y       <= sety_q;
            state_q           <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_seg_in_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q <= count_q)
    else $error("segment index beyond path count");

  a_arrive_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.arrived |-> out_q.cell_update && out_q.active)
    else $error("arrival without final cell");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.active |-> !out_q.cell_update && !out_q.arrived)
    else $error("path work reported with no active path");

  a_brg_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brg_done |-> state_q == S_BRG)
    else $error("bearing finished outside its wait state");

endmodule

[bench/wpf_route_checker.sv]
// Watches both channels of the waypoint path follower, predicts each result word
// and compares it field by field. Depends on wpf_pkg and wpf_in_if/wpf_out_if.
module wpf_route_checker #(
  parameter int MAX_WAYPOINTS = 16,
  parameter int CELL_SIZE     = 100
) (
  input  logic clk_i,
  input  logic rst_ni,
  wpf_in_if    in_i,
  wpf_out_if   out_i,
  output int   errors_o,
  output int   pending_o
);

  localparam longint FINE_FULL = 360 * 16384;
  localparam longint ATAN_TBL [16] = '{737280, 435242, 229970, 116736, 58595, 29326,
                                       14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
  localparam longint CUBIC_W [3][4] = '{'{-9, 111, 29, -3}, '{-8, 72, 72, -8},
                                        '{-3, 29, 111, -9}};
  localparam longint FULL_T = longint'(wpf_pkg::FULL_TURN);
  localparam longint HALF_T = longint'(wpf_pkg::HALF_TURN);

  logic [7:0] col_mem [MAX_WAYPOINTS];
  logic [7:0] row_mem [MAX_WAYPOINTS];
  int unsigned path_len, seg, sub;
  wpf_pkg::out_t  result_q [$];
  int    errors;

  assign errors_o  = errors;
  assign pending_o = result_q.size();

  function automatic longint cell_centre(logic [7:0] c);
    return (2 * longint'(c) + 1) * CELL_SIZE * 8;
  endfunction

  function automatic longint clip20(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  // Bearing from mover to set point in 1/64 degree; 0 toward -y, 90 toward +x.
  function automatic longint bearing_of(longint nx, longint ny);
    longint x, y, z, xn, fine, b;
    if (nx == 0) return (ny < 0) ? 0 : HALF_T;
    if (ny == 0) return (nx < 0) ? longint'(wpf_pkg::TQTR_TURN) : longint'(wpf_pkg::QTR_TURN);
    x = nx * 1048576;
    y = ny * 1048576;
    z = 0;
    if (nx < 0) begin
      x = -x;
      y = -y;
      z = 180 * 16384;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN_TBL[i];
      end else begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN_TBL[i];
      end
      x = xn;
    end
    fine = z + 90 * 16384;
    if (fine < 0) fine += FINE_FULL;
    if (fine >= FINE_FULL) fine -= FINE_FULL;
    b = (fine + 128) >>> 8;
    if (b >= FULL_T) b -= FULL_T;
    return b;
  endfunction

  // Turn by half the gap, worked in 1/128 degree.
  function automatic longint halve_gap(longint h, longint b, longint d);
    longint full2, half2, hh, bb, aa, r;
    full2 = 2 * FULL_T;
    half2 = FULL_T;
    hh = 2 * h;
    bb = 2 * b;
    if (hh < half2) begin
      aa = hh - d;
      if (bb >= hh + d && bb < hh + half2) r = hh + d;
      else if (aa >= 0 && (bb >= hh + half2 || bb < aa)) r = aa;
      else if (aa < 0 && (bb >= hh + half2 && bb < aa + full2)) r = aa + full2;
      else r = bb;
    end else begin
      aa = hh + d;
      if (bb < hh - d && bb >= hh - half2) r = hh - d;
      else if (aa < full2 && (bb < hh - half2 || bb >= aa)) r = aa;
      else if (aa >= full2 && (bb < hh - half2 && bb >= aa - full2)) r = aa - full2;
      else r = bb;
    end
    r = (r + 1) >>> 1;
    if (r >= FULL_T) r -= FULL_T;
    return r;
  endfunction

  function automatic wpf_pkg::out_t follow_word(wpf_pkg::in_t w);
    wpf_pkg::out_t r;
    longint hdg, h_out, sx, sy, px, py, dx, dy, b, d;
    longint xs [4];
    longint ys [4];
    int unsigned last, t, k;
    logic arrived;
    r = '0;
    arrived = 1'b0;
    hdg = longint'(w.heading);
    if (hdg >= FULL_T) hdg -= FULL_T;
    h_out = hdg;
    sx = 0;
    sy = 0;
    case (wpf_pkg::op_e'(w.operation))
      wpf_pkg::OP_WRITE: begin
        col_mem[w.waypoint_index] = w.waypoint_x;
        row_mem[w.waypoint_index] = w.waypoint_y;
        r.active = seg < path_len;
      end
      wpf_pkg::OP_START: begin
        path_len = (w.path_count > MAX_WAYPOINTS) ? MAX_WAYPOINTS : w.path_count;
        seg = 0;
        sub = 0;
        r.active = path_len != 0;
      end
      wpf_pkg::OP_STEP: begin
        r.active = seg < path_len;
        if (r.active) begin
          last = path_len - 1;
          if (sub == 0) begin
            t = (seg + 1 > last) ? last : seg + 1;
            r.cell_update = 1'b1;
            r.cell_x = col_mem[t];
            r.cell_y = row_mem[t];
          end
          for (int i = 0; i < 4; i++) begin
            k = (seg + i < 1) ? 0 : seg + i - 1;
            if (k > last) k = last;
            xs[i] = cell_centre(col_mem[k]);
            ys[i] = cell_centre(row_mem[k]);
          end
          if (sub >= 3) begin
            sx = xs[2];
            sy = ys[2];
          end else begin
            for (int i = 0; i < 4; i++) begin
              sx += CUBIC_W[sub][i] * xs[i];
              sy += CUBIC_W[sub][i] * ys[i];
            end
            sx = clip20((sx + 64) >>> 7);
            sy = clip20((sy + 64) >>> 7);
          end
          px = longint'(w.pos_x);
          py = longint'(w.pos_y);
          dx = px - sx;
          dy = py - sy;
          if (dx * dx + dy * dy <= longint'(wpf_pkg::NEAR_SQ)) begin
            sub++;
            if (sub > 3) begin
              sub = 0;
              seg++;
              if (seg >= last) begin
                seg = last;
                r.cell_update = 1'b1;
                r.cell_x = col_mem[last];
                r.cell_y = row_mem[last];
                arrived = 1'b1;
              end
            end
          end
          if (!arrived && w.turn_enable) begin
            b = bearing_of(sx - px, sy - py);
            d = b - hdg;
            if (hdg < HALF_T) begin
              if (b >= hdg + HALF_T) d = FULL_T - b + hdg;
            end else begin
              if (b < hdg - HALF_T) d = FULL_T - hdg + b;
            end
            if (d < 0) d = -d;
            h_out = (d >= longint'(wpf_pkg::SNAP_GAP)) ? b : halve_gap(hdg, b, d);
          end
        end
      end
      default: r.active = seg < path_len;
    endcase
    r.heading_out = h_out[14:0];
    r.arrived = arrived;
    r.set_x = sx[19:0];
    r.set_y = sy[19:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wpf_pkg::out_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WAYPOINTS; i++) begin
        col_mem[i] = '0;
        row_mem[i] = '0;
      end
      path_len = 0;
      seg = 0;
      sub = 0;
      result_q.delete();
      errors = 0;
    end else begin
      // Compare the result first: it belongs to an earlier word than the one taken now.
      if (out_i.valid && out_i.ready) begin
        got = out_i.data;
        if (result_q.size() == 0) begin
          $error("result word with nothing expected");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (got.heading_out !== want.heading_out) begin
            $error("heading_out: expected %0d, got %0d", want.heading_out, got.heading_out);
            errors++;
          end
          if (got.arrived !== want.arrived) begin
            $error("arrived: expected %0d, got %0d", want.arrived, got.arrived);
            errors++;
          end
          if (got.active !== want.active) begin
            $error("active: expected %0d, got %0d", want.active, got.active);
            errors++;
          end
          if (got.cell_update !== want.cell_update) begin
            $error("cell_update: expected %0d, got %0d", want.cell_update, got.cell_update);
            errors++;
          end
          if (got.cell_x !== want.cell_x) begin
            $error("cell_x: expected %0d, got %0d", want.cell_x, got.cell_x);
            errors++;
          end
          if (got.cell_y !== want.cell_y) begin
            $error("cell_y: expected %0d, got %0d", want.cell_y, got.cell_y);
            errors++;
          end
          if (got.set_x !== want.set_x) begin
            $error("set_x: expected %0d, got %0d", want.set_x, got.set_x);
            errors++;
          end
          if (got.set_y !== want.set_y) begin
            $error("set_y: expected %0d, got %0d", want.set_y, got.set_y);
            errors++;
          end
        end
      end
      if (in_i.valid && in_i.ready) result_q.push_back(follow_word(in_i.data));
    end
  end

endmodule

[bench/testbench.sv]
// Stimulus and verdict for the waypoint path follower: drives words into the
// block, toggles back-pressure. Depends on wpf_pkg, the channels and wpf_route_checker.
module testbench;

  localparam int     WORD_TARGET = 1450;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk_i;
  logic rst_ni;
  int   errors, pending, sent;
  int   send_idle, take_idle;
  longint cycles;

  wpf_in_if  in_ch ();
  wpf_out_if out_ch ();

  spline_waypoint_path_follower u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  wpf_route_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_ch),
    .out_i     (out_ch),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle pattern by progress: receiver lazy first, then sender lazy, then none.
  always_comb begin
    if (sent < WORD_TARGET / 3) begin
      send_idle = 37;
      take_idle = 78;
    end else if (sent < 2 * WORD_TARGET / 3) begin
      send_idle = 78;
      take_idle = 37;
    end else begin
      send_idle = 0;
      take_idle = 0;
    end
  end

  // Stall the result side at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= take_idle);
  end

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic wpf_pkg::in_t blank_word(wpf_pkg::op_e op);
    wpf_pkg::in_t w;
    w = '0;
    w.operation = op;
    w.waypoint_index = 4'($urandom);
    w.waypoint_x = 8'($urandom);
    w.waypoint_y = 8'($urandom);
    w.path_count = 5'($urandom);
    w.pos_x = 20'($urandom);
    w.pos_y = 20'($urandom);
    w.heading = 15'($urandom);
    w.turn_enable = 1'($urandom);
    return w;
  endfunction

  // Hold a word until the block takes it; idle before it at random.
  task automatic send_word(wpf_pkg::in_t w);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    // sample ready mid-cycle, away from the edge that updates it
    do @(negedge clk_i); while (!in_ch.ready);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic put_waypoint(int idx, int cx, int cy);
    wpf_pkg::in_t w;
    w = blank_word(wpf_pkg::OP_WRITE);
    w.waypoint_index = 4'(idx);
    w.waypoint_x = 8'(cx);
    w.waypoint_y = 8'(cy);
    send_word(w);
  endtask

  task automatic start_path(int n);
    wpf_pkg::in_t w;
    w = blank_word(wpf_pkg::OP_START);
    w.path_count = 5'(n);
    send_word(w);
  endtask

  // Step with the mover near the centre of cell (cx, cy), jittered by j.
  task automatic step_near(int cx, int cy, int j);
    wpf_pkg::in_t w;
    w = blank_word(wpf_pkg::OP_STEP);
    w.pos_x = 20'((2 * cx + 1) * 800 + $urandom_range(0, 2 * j) - j);
    w.pos_y = 20'((2 * cy + 1) * 800 + $urandom_range(0, 2 * j) - j);
    send_word(w);
  endtask

  initial begin
    wpf_pkg::in_t w;
    int  cx, cy, n, spread, steps;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    sent = 0;
    cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a step before any path exists, the ignored code, empty start.
    send_word(blank_word(wpf_pkg::OP_STEP));
    send_word(blank_word(wpf_pkg::OP_NONE));
    start_path(0);
    // Fill every store slot so no step can touch an unwritten one.
    for (int i = 0; i < 16; i++) put_waypoint(i, (i == 15) ? 255 : 5, (i == 0) ? 0 : 5);
    put_waypoint(0, 0, 255);
    put_waypoint(15, 255, 0);
    start_path(31);  // saturates to the full store
    w = blank_word(wpf_pkg::OP_STEP);
    w.pos_x = 20'sh80000;
    w.pos_y = 20'sh7FFFF;
    w.heading = 15'd32767;
    w.turn_enable = 1'b1;
    send_word(w);
    w.pos_x = 20'sh7FFFF;
    w.pos_y = 20'sh80000;
    w.heading = 15'd23039;
    send_word(w);
    // Single waypoint path: four hits reach arrival; exact hit gives bearing 180.
    put_waypoint(0, 7, 9);
    start_path(1);
    for (int i = 0; i < 5; i++) begin
      w = blank_word(wpf_pkg::OP_STEP);
      w.pos_x = 20'(15 * 800);
      w.pos_y = 20'(19 * 800);
      w.turn_enable = 1'b1;
      w.heading = 15'd0;
      send_word(w);
    end

    // Random: mostly well-formed paths of nearby cells walked step by step.
    while (sent < WORD_TARGET) begin
      if ($urandom_range(99) < 15) begin
        w = blank_word(wpf_pkg::op_e'($urandom_range(0, 3)));
        send_word(w);
      end else begin
        cx = $urandom_range(0, 254);
        cy = $urandom_range(0, 254);
        spread = $urandom_range(0, 1);
        n = ($urandom_range(9) == 0) ? 16 : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
          put_waypoint(i, cx + $urandom_range(0, spread), cy + $urandom_range(0, spread));
        start_path(($urandom_range(19) == 0) ? $urandom_range(17, 31) : n);
        steps = $urandom_range(5, 30);
        for (int i = 0; i < steps; i++) begin
          if ($urandom_range(9) == 0) send_word(blank_word(wpf_pkg::OP_STEP));
          else step_near(cx, cy, $urandom_range(0, 1) ? 300 : 1200);
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow the slowest item's latency.
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
